### sv/ifrm_pkg.sv
// Shared types and constants for the interval and frame rate meter.
// Beat structs, sequencer states, divider request/response and fixed-point constants.
// No dependencies.
package ifrm_pkg;

    localparam int TS_W       = 48;
    localparam int AVGI_W     = 56;
    localparam int RATE_W     = 24;
    localparam int DISP_W     = 20;
    localparam int TPS_W      = 32;
    localparam int OVH_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // serial divider sizes
    localparam int DVD_W = 61;
    localparam int DSR_W = 48;
    localparam int CNT_W = 6;
    localparam int ACC_W = DVD_W;

    // display math is done on 28-bit tenths*256 values
    localparam int DM_W = 28;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STOP  = 1'b1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DUP_START = 2'd1;
    localparam logic [1:0] STAT_NO_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TPS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVH = 8'd1;

    localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000000;

    localparam logic [DSR_W-1:0] DIV_I_DSR = 48'd20;
    localparam logic [DSR_W-1:0] DIV_A_DSR = 48'd100;
    localparam logic [DSR_W-1:0] DIV_B_DSR = 48'd5;

    localparam logic [CNT_W-1:0] CNT_I = 6'd61;
    localparam logic [CNT_W-1:0] CNT_R = 6'd49;
    localparam logic [CNT_W-1:0] CNT_A = 6'd31;
    localparam logic [CNT_W-1:0] CNT_B = 6'd27;

    localparam logic [7:0]        AVGI_RND  = 8'd10;
    localparam logic [ACC_W-1:0]  AR_RND    = 61'd50;
    localparam logic [ACC_W-1:0]  AR5_RND   = 61'd2;
    localparam logic [RATE_W-1:0] RATE_MAX  = 24'hFFFFFF;
    localparam logic [RATE_W-1:0] RATE_20   = 24'd5120;
    localparam logic [DM_W-1:0]   DEV_LO    = 28'd1920;
    localparam logic [DM_W-1:0]   DEV_HI    = 28'd3200;
    localparam logic [DM_W-1:0]   DISP_RND  = 28'd128;

    typedef struct packed {
        logic            cmd;
        logic [TS_W-1:0] time_stamp;
        logic [TS_W-1:0] cycle_stamp;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TS_W-1:0]   last_interval;
        logic [AVGI_W-1:0] average_interval;
        logic [TS_W-1:0]   net_cycles;
        logic              rate_valid;
        logic [RATE_W-1:0] raw_rate;
        logic [RATE_W-1:0] average_rate;
        logic [DISP_W-1:0] display_rate_tenths;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic accept;
        logic out_free;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic load;
    } core_stat_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CHECK,
        S_DIFF,
        S_NET,
        S_CMP_I,
        S_ACC_I1,
        S_ACC_I2,
        S_DIV_I,
        S_DIV_WAIT,
        S_SAVE_I,
        S_RATE,
        S_DIV_R,
        S_SAVE_R,
        S_AR0,
        S_AR1,
        S_AR2,
        S_AR3,
        S_AR4,
        S_DIV_A,
        S_SAVE_A,
        S_ABS_A,
        S_CMP_A,
        S_AR5,
        S_DIV_B,
        S_SAVE_B,
        S_DISP0,
        S_DISP1,
        S_DISP2,
        S_LAST,
        S_DONE
    } state_t;

endpackage

### sv/ifrm_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, dividend shifted in MSB first.
// Depends on ifrm_pkg (div_req_t, div_rsp_t, widths).
module ifrm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ifrm_pkg::div_req_t req,
    output ifrm_pkg::div_rsp_t rsp
);
    import ifrm_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] trial_sub;
    logic           ge;

    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign ge        = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits DSR_W bits
            rem_next = ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            quo_next  = '0;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/ifrm_core.sv
// Measurement sequencer: stamps, interval and rate averages, display hysteresis.
// Depends on ifrm_pkg; instantiates ifrm_div for all divisions.
module ifrm_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ifrm_pkg::core_ctl_t           ctl,
    input  ifrm_pkg::in_item_t            item,
    input  logic [ifrm_pkg::TPS_W-1:0]   tps,
    input  logic [ifrm_pkg::OVH_W-1:0]   ovh,
    output ifrm_pkg::core_stat_t          stat,
    output ifrm_pkg::out_item_t           result
);
    import ifrm_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic              running_reg, running_next;
    logic              have_last_reg, have_last_next;
    logic              rate_ok_reg, rate_ok_next;
    logic [1:0]        status_reg, status_next;
    logic [TS_W-1:0]   start_time_reg, start_time_next;
    logic [TS_W-1:0]   start_cyc_reg, start_cyc_next;
    logic [TS_W-1:0]   last_stop_reg, last_stop_next;
    logic [TS_W-1:0]   interval_reg, interval_next;
    logic [AVGI_W-1:0] avg_int_reg, avg_int_next;
    logic [TS_W-1:0]   cycles_reg, cycles_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [RATE_W-1:0] avg_rate_reg, avg_rate_next;
    logic [DISP_W-1:0] disp_reg, disp_next;

    in_item_t          item_reg, item_next;
    logic [TS_W-1:0]   cdiff_reg, cdiff_next;
    logic [TS_W-1:0]   gap_reg, gap_next;
    logic [AVGI_W-1:0] absd_reg, absd_next;
    logic [AVGI_W-1:0] max_reg, max_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [RATE_W-1:0] ar_reg, ar_next;
    logic [DM_W-1:0]   m10_reg, m10_next;
    logic [DM_W-1:0]   r10_reg, r10_next;
    logic [DM_W-1:0]   dev_reg, dev_next;
    logic [16:0]       arr_reg, arr_next;
    logic              le20_reg, le20_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [AVGI_W-1:0] i8;
    logic [AVGI_W:0]   sub_ai;
    logic [AVGI_W-1:0] sub_ia;
    logic [TS_W:0]     net_diff;
    logic              big_i;
    logic [RATE_W:0]   sub_ar;
    logic [RATE_W-1:0] sub_ra;
    logic              big_a;
    logic [DM_W-1:0]   d256;
    logic [DM_W:0]     sub_dm;
    logic [DM_W-1:0]   sub_md;
    logic [ACC_W-1:0]  a_x18;
    logic [ACC_W-1:0]  r_x96;
    logic [RATE_W:0]   ar_plus;
    logic [DM_W-1:0]   r10_rnd;
    logic [DM_W-1:0]   m10_rnd;
    logic [20:0]       arr_x10;

    ifrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign i8       = {interval_reg, 8'd0};
    assign sub_ai   = {1'b0, avg_int_reg} - {1'b0, i8};
    assign sub_ia   = i8 - avg_int_reg;
    assign net_diff = {1'b0, cdiff_reg} - (TS_W+1)'(ovh);
    assign big_i    = {absd_reg, 1'b0} > {1'b0, max_reg};
    assign sub_ar   = {1'b0, ar_reg} - {1'b0, rate_reg};
    assign sub_ra   = rate_reg - ar_reg;
    assign big_a    = {absd_reg[RATE_W-1:0], 2'b00} > {2'b00, max_reg[RATE_W-1:0]};
    assign d256     = {disp_reg, 8'd0};
    assign sub_dm   = {1'b0, d256} - {1'b0, m10_reg};
    assign sub_md   = m10_reg - d256;
    // 18*avg, then +avg later: 19*avg
    assign a_x18    = ACC_W'({avg_int_reg, 4'd0}) + ACC_W'({avg_int_reg, 1'b0});
    // 96*avg, then +2*avg and +avg: 99*avg
    assign r_x96    = ACC_W'({avg_rate_reg, 6'd0}) + ACC_W'({avg_rate_reg, 5'd0});
    assign ar_plus  = {1'b0, ar_reg} + (RATE_W+1)'(DISP_RND);
    assign r10_rnd  = r10_reg + DISP_RND;
    assign m10_rnd  = m10_reg + DISP_RND;
    assign arr_x10  = {1'b0, arr_reg, 3'd0} + {3'd0, arr_reg, 1'b0};

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        running_next    = running_reg;
        have_last_next  = have_last_reg;
        rate_ok_next    = rate_ok_reg;
        status_next     = status_reg;
        start_time_next = start_time_reg;
        start_cyc_next  = start_cyc_reg;
        last_stop_next  = last_stop_reg;
        interval_next   = interval_reg;
        avg_int_next    = avg_int_reg;
        cycles_next     = cycles_reg;
        rate_next       = rate_reg;
        avg_rate_next   = avg_rate_reg;
        disp_next       = disp_reg;
        item_next       = item_reg;
        cdiff_next      = cdiff_reg;
        gap_next        = gap_reg;
        absd_next       = absd_reg;
        max_next        = max_reg;
        acc_next        = acc_reg;
        ar_next         = ar_reg;
        m10_next        = m10_reg;
        r10_next        = r10_reg;
        dev_next        = dev_reg;
        arr_next        = arr_reg;
        le20_next       = le20_reg;

        div_req.start    = 1'b0;
        div_req.count    = CNT_I;
        div_req.dividend = acc_reg;
        div_req.divisor  = DIV_I_DSR;

        stat.idle = (state_reg == S_IDLE);
        stat.load = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept)
                begin
                    item_next  = item;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = STAT_OK;
                state_next  = S_DONE;
                if (item_reg.cmd == CMD_START)
                begin
                    if (running_reg)
                        status_next = STAT_DUP_START;
                    else
                    begin
                        running_next    = 1'b1;
                        start_time_next = item_reg.time_stamp;
                        start_cyc_next  = item_reg.cycle_stamp;
                    end
                end
                else if (!running_reg)
                    status_next = STAT_NO_START;
                else
                    state_next = S_DIFF;
            end
            S_DIFF:
            begin
                interval_next = item_reg.time_stamp - start_time_reg;
                cdiff_next    = item_reg.cycle_stamp - start_cyc_reg;
                gap_next      = item_reg.time_stamp - last_stop_reg;
                state_next    = S_NET;
            end
            S_NET:
            begin
                cycles_next = net_diff[TS_W] ? '0 : net_diff[TS_W-1:0];
                if (sub_ai[AVGI_W])
                begin
                    absd_next = sub_ia;
                    max_next  = i8;
                end
                else
                begin
                    absd_next = sub_ai[AVGI_W-1:0];
                    max_next  = avg_int_reg;
                end
                state_next = S_CMP_I;
            end
            S_CMP_I:
            begin
                acc_next = a_x18;
                if (big_i)
                begin
                    // jump of more than half: restart the average
                    avg_int_next = i8;
                    state_next   = S_RATE;
                end
                else
                    state_next = S_ACC_I1;
            end
            S_ACC_I1:
            begin
                acc_next   = acc_reg + ACC_W'(avg_int_reg);
                state_next = S_ACC_I2;
            end
            S_ACC_I2:
            begin
                // i8 has zero low byte, so the rounding term drops in there
                acc_next   = acc_reg + ACC_W'({interval_reg, AVGI_RND});
                state_next = S_DIV_I;
            end
            S_DIV_I:
            begin
                div_req.start    = 1'b1;
                div_req.count    = CNT_I;
                div_req.dividend = acc_reg;
                div_req.divisor  = DIV_I_DSR;
                ret_next         = S_SAVE_I;
                state_next       = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ret_reg;
            end
            S_SAVE_I:
            begin
                avg_int_next = div_rsp.quotient[AVGI_W-1:0];
                state_next   = S_RATE;
            end
            S_RATE:
            begin
                if (!have_last_reg)
                    state_next = S_LAST;
                else if (gap_reg == '0)
                begin
                    rate_next  = RATE_MAX;
                    state_next = S_AR0;
                end
                else
                begin
                    acc_next   = ACC_W'({tps, 8'd0}) + ACC_W'(gap_reg[TS_W-1:1]);
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                div_req.start    = 1'b1;
                div_req.count    = CNT_R;
                div_req.dividend = {acc_reg[48:0], 12'd0};
                div_req.divisor  = gap_reg;
                ret_next         = S_SAVE_R;
                state_next       = S_DIV_WAIT;
            end
            S_SAVE_R:
            begin
                if (|div_rsp.quotient[DVD_W-1:RATE_W])
                    rate_next = RATE_MAX;
                else
                    rate_next = div_rsp.quotient[RATE_W-1:0];
                state_next = S_AR0;
            end
            S_AR0:
            begin
                acc_next   = r_x96;
                state_next = S_AR1;
            end
            S_AR1:
            begin
                acc_next   = acc_reg + ACC_W'({avg_rate_reg, 1'b0});
                state_next = S_AR2;
            end
            S_AR2:
            begin
                acc_next   = acc_reg + ACC_W'(avg_rate_reg);
                state_next = S_AR3;
            end
            S_AR3:
            begin
                acc_next   = acc_reg + ACC_W'(rate_reg);
                state_next = S_AR4;
            end
            S_AR4:
            begin
                acc_next   = acc_reg + AR_RND;
                state_next = S_DIV_A;
            end
            S_DIV_A:
            begin
                div_req.start    = 1'b1;
                div_req.count    = CNT_A;
                div_req.dividend = {acc_reg[30:0], 30'd0};
                div_req.divisor  = DIV_A_DSR;
                ret_next         = S_SAVE_A;
                state_next       = S_DIV_WAIT;
            end
            S_SAVE_A:
            begin
                ar_next    = div_rsp.quotient[RATE_W-1:0];
                state_next = S_ABS_A;
            end
            S_ABS_A:
            begin
                if (sub_ar[RATE_W])
                begin
                    absd_next = AVGI_W'(sub_ra);
                    max_next  = AVGI_W'(rate_reg);
                end
                else
                begin
                    absd_next = AVGI_W'(sub_ar[RATE_W-1:0]);
                    max_next  = AVGI_W'(ar_reg);
                end
                state_next = S_CMP_A;
            end
            S_CMP_A:
            begin
                acc_next = ACC_W'({ar_reg, 2'b00}) + ACC_W'(rate_reg);
                // off by a quarter: second, faster blend on top of the slow one
                if (big_a)
                    state_next = S_AR5;
                else
                    state_next = S_DISP0;
            end
            S_AR5:
            begin
                acc_next   = acc_reg + AR5_RND;
                state_next = S_DIV_B;
            end
            S_DIV_B:
            begin
                div_req.start    = 1'b1;
                div_req.count    = CNT_B;
                div_req.dividend = {acc_reg[26:0], 34'd0};
                div_req.divisor  = DIV_B_DSR;
                ret_next         = S_SAVE_B;
                state_next       = S_DIV_WAIT;
            end
            S_SAVE_B:
            begin
                ar_next    = div_rsp.quotient[RATE_W-1:0];
                state_next = S_DISP0;
            end
            S_DISP0:
            begin
                avg_rate_next = ar_reg;
                m10_next      = DM_W'({ar_reg, 3'd0}) + DM_W'({ar_reg, 1'b0});
                r10_next      = DM_W'({rate_reg, 3'd0}) + DM_W'({rate_reg, 1'b0});
                state_next    = S_DISP1;
            end
            S_DISP1:
            begin
                // deviation of display from average, in 1/2560 units
                dev_next   = sub_dm[DM_W] ? sub_md : sub_dm[DM_W-1:0];
                arr_next   = ar_plus[RATE_W:8];
                le20_next  = (ar_reg <= RATE_20);
                state_next = S_DISP2;
            end
            S_DISP2:
            begin
                if (disp_reg == '0)
                    disp_next = r10_rnd[DM_W-1:8];
                else if (le20_reg)
                begin
                    if (dev_reg > DEV_LO)
                        disp_next = m10_rnd[DM_W-1:8];
                end
                else if (dev_reg > DEV_HI)
                    disp_next = arr_x10[DISP_W-1:0];
                rate_ok_next = 1'b1;
                state_next   = S_LAST;
            end
            S_LAST:
            begin
                last_stop_next = item_reg.time_stamp;
                have_last_next = 1'b1;
                running_next   = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (ctl.out_free)
                begin
                    stat.load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            running_reg    <= 1'b0;
            have_last_reg  <= 1'b0;
            rate_ok_reg    <= 1'b0;
            status_reg     <= STAT_OK;
            start_time_reg <= '0;
            start_cyc_reg  <= '0;
            last_stop_reg  <= '0;
            interval_reg   <= '0;
            avg_int_reg    <= '0;
            cycles_reg     <= '0;
            rate_reg       <= '0;
            avg_rate_reg   <= '0;
            disp_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            running_reg    <= running_next;
            have_last_reg  <= have_last_next;
            rate_ok_reg    <= rate_ok_next;
            status_reg     <= status_next;
            start_time_reg <= start_time_next;
            start_cyc_reg  <= start_cyc_next;
            last_stop_reg  <= last_stop_next;
            interval_reg   <= interval_next;
            avg_int_reg    <= avg_int_next;
            cycles_reg     <= cycles_next;
            rate_reg       <= rate_next;
            avg_rate_reg   <= avg_rate_next;
            disp_reg       <= disp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        cdiff_reg <= cdiff_next;
        gap_reg   <= gap_next;
        absd_reg  <= absd_next;
        max_reg   <= max_next;
        acc_reg   <= acc_next;
        ar_reg    <= ar_next;
        m10_reg   <= m10_next;
        r10_reg   <= r10_next;
        dev_reg   <= dev_next;
        arr_reg   <= arr_next;
        le20_reg  <= le20_next;
    end

    assign result.status              = status_reg;
    assign result.last_interval       = interval_reg;
    assign result.average_interval    = avg_int_reg;
    assign result.net_cycles          = cycles_reg;
    assign result.rate_valid          = rate_ok_reg;
    assign result.raw_rate            = rate_reg;
    assign result.average_rate        = avg_rate_reg;
    assign result.display_rate_tenths = disp_reg;

endmodule

### sv/interval_and_frame_rate_meter_top.sv
// Top level of the interval and frame rate meter: ports, config registers, output register.
// Depends on ifrm_pkg; instantiates ifrm_core.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_data (in_item_t)
//  out      output     out_valid / out_stall out_data (out_item_t)
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Start and error beats go from the check state to the done state, which loads the output
// register; stop beats first run up to four divides of 61, 49, 31 and 27 bits, one bit per cycle.
// One beat is in work at a time; in_stall is high until the result enters the output register,
// so the next beat can be taken in the cycle after that.
// The output register holds one result while the next beat is accepted and worked on.
// rst_n clears all measurement state and sets ticks_per_second to 1000000.
module interval_and_frame_rate_meter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ifrm_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ifrm_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ifrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ifrm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ifrm_pkg::*;

    logic [TPS_W-1:0] tps_reg, tps_next;
    logic [OVH_W-1:0] ovh_reg, ovh_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    core_ctl_t  ctl;
    core_stat_t stat;
    out_item_t  result;

    ifrm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (in_data),
        .tps    (tps_reg),
        .ovh    (ovh_reg),
        .stat   (stat),
        .result (result)
    );

    assign in_stall     = !stat.idle;
    assign cfg_ready    = 1'b1;
    assign ctl.accept   = in_valid && stat.idle;
    assign ctl.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        tps_next = tps_reg;
        ovh_next = ovh_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TPS: tps_next = cfg_data[TPS_W-1:0];
                REG_OVH: ovh_next = cfg_data[OVH_W-1:0];
                default: ;
            endcase
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (stat.load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= TPS_RESET;
            ovh_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tps_reg       <= tps_next;
            ovh_reg       <= ovh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
